FILE: rtl/rbst_pkg.sv
// shared types and constants for the ray against box slab test
// no dependencies

package rbst_pkg;

	localparam int NUM_AXES = 3;

	typedef struct packed {
		logic zero_dir;
		logic in_slab;
	} axis_flag_t;

	typedef axis_flag_t [NUM_AXES-1:0] ray_flag_t;

endpackage

FILE: rtl/rbst_slab_div.sv
// pipelined saturating fixed-point divide, one quotient bit per stage
// quotient of num * 2^FRACTION_BITS by den, magnitude truncated, saturated
// depends on nothing but its parameters

module rbst_slab_div #(
	parameter int COORD_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [COORD_WIDTH:0]   num,
	input  logic signed [COORD_WIDTH-1:0] den,
	output logic signed [COORD_WIDTH-1:0] quo
);

	localparam int W  = COORD_WIDTH;
	localparam int QW = COORD_WIDTH + 1 + FRACTION_BITS;

	logic [W:0]    nabs;
	logic [W-1:0]  dabs;

	logic [W-1:0]  rem_s  [0:QW];
	logic [QW-1:0] quo_s  [0:QW];
	logic [QW-1:0] num_s  [0:QW];
	logic [W-1:0]  dmag_s [0:QW];
	logic          neg_s  [0:QW];

	logic [QW-1:0] lim;
	logic [W-1:0]  qmag;

	assign nabs = num[W] ? (~num + 1'b1) : num;
	assign dabs = den[W-1] ? (~den + 1'b1) : den;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			quo_s[0]  <= '0;
			num_s[0]  <= QW'(nabs) << FRACTION_BITS;
			dmag_s[0] <= dabs;
			neg_s[0]  <= num[W] ^ den[W-1];
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [W:0] trial;
		logic [W:0] diff;
		logic       ge;

		assign trial = {rem_s[k], num_s[k][QW-1-k]};
		assign diff  = trial - {1'b0, dmag_s[k]};
		assign ge    = trial >= {1'b0, dmag_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[W-1:0] : trial[W-1:0];
				quo_s[k+1]  <= {quo_s[k][QW-2:0], ge};
				num_s[k+1]  <= num_s[k];
				dmag_s[k+1] <= dmag_s[k];
				neg_s[k+1]  <= neg_s[k];
			end
		end
	end

	// saturation limit depends on the sign of the result
	assign lim  = (QW'(1) << (W-1)) - QW'(!neg_s[QW]);
	assign qmag = (quo_s[QW] > lim) ? lim[W-1:0] : quo_s[QW][W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= neg_s[QW] ? (~qmag + 1'b1) : qmag;
		end
	end

endmodule

FILE: rtl/ray_box_slab_test.sv
// ray against axis-aligned box slab test, hit flag per word
// one word per cycle while no untaken result holds the pipeline
// the six bit-per-stage slab dividers work in parallel and are fully pipelined
// the whole pipeline stalls as one when a valid result is not taken
// arst_n clears all valid bits; data registers are not reset
// depends on rbst_pkg and rbst_slab_div

module ray_box_slab_test #(
	parameter int COORD_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] ray_origin_x,
	input  logic signed [COORD_WIDTH-1:0] ray_origin_y,
	input  logic signed [COORD_WIDTH-1:0] ray_origin_z,
	input  logic signed [COORD_WIDTH-1:0] ray_dir_x,
	input  logic signed [COORD_WIDTH-1:0] ray_dir_y,
	input  logic signed [COORD_WIDTH-1:0] ray_dir_z,
	input  logic signed [COORD_WIDTH-1:0] box_min_x,
	input  logic signed [COORD_WIDTH-1:0] box_min_y,
	input  logic signed [COORD_WIDTH-1:0] box_min_z,
	input  logic signed [COORD_WIDTH-1:0] box_max_x,
	input  logic signed [COORD_WIDTH-1:0] box_max_y,
	input  logic signed [COORD_WIDTH-1:0] box_max_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit
);

	localparam int W  = COORD_WIDTH;
	localparam int NA = rbst_pkg::NUM_AXES;
	localparam int DL = COORD_WIDTH + 1 + FRACTION_BITS + 2;

	logic en;

	logic signed [W-1:0] org [NA];
	logic signed [W-1:0] dir [NA];
	logic signed [W-1:0] lo  [NA];
	logic signed [W-1:0] hi  [NA];

	logic signed [W:0]   dlo_s1 [NA];
	logic signed [W:0]   dhi_s1 [NA];
	logic signed [W-1:0] dir_s1 [NA];

	rbst_pkg::ray_flag_t flg_s [0:DL];
	logic                vld_s [0:DL];

	logic signed [W-1:0] tlo [NA];
	logic signed [W-1:0] thi [NA];

	logic signed [W-1:0] tin_s2  [NA];
	logic signed [W-1:0] tout_s2 [NA];
	logic                miss_s2;
	logic                vld_s2;

	logic signed [W-1:0] in_max;
	logic signed [W-1:0] out_min;
	logic signed [W-1:0] tmax_s3;
	logic signed [W-1:0] tmin_s3;
	logic                miss_s3;
	logic                vld_s3;

	logic                miss_any;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	assign org = '{ray_origin_x, ray_origin_y, ray_origin_z};
	assign dir = '{ray_dir_x, ray_dir_y, ray_dir_z};
	assign lo  = '{box_min_x, box_min_y, box_min_z};
	assign hi  = '{box_max_x, box_max_y, box_max_z};

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NA; a++) begin
				dlo_s1[a] <= {lo[a][W-1], lo[a]} - {org[a][W-1], org[a]};
				dhi_s1[a] <= {hi[a][W-1], hi[a]} - {org[a][W-1], org[a]};
				dir_s1[a] <= dir[a];
				flg_s[0][a].zero_dir <= dir[a] == '0;
				flg_s[0][a].in_slab  <= (org[a] >= lo[a] && org[a] <= hi[a]) ||
					(org[a] >= hi[a] && org[a] <= lo[a]);
			end
			for (int j = 1; j <= DL; j++) begin
				flg_s[j] <= flg_s[j-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= DL; j++) begin
				vld_s[j] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int j = 1; j <= DL; j++) begin
				vld_s[j] <= vld_s[j-1];
			end
		end
	end

	for (genvar a = 0; a < NA; a++) begin : g_axis
		rbst_slab_div #(
			.COORD_WIDTH  (COORD_WIDTH),
			.FRACTION_BITS(FRACTION_BITS)
		) u_div_lo (
			.clk(clk),
			.en (en),
			.num(dlo_s1[a]),
			.den(dir_s1[a]),
			.quo(tlo[a])
		);

		rbst_slab_div #(
			.COORD_WIDTH  (COORD_WIDTH),
			.FRACTION_BITS(FRACTION_BITS)
		) u_div_hi (
			.clk(clk),
			.en (en),
			.num(dhi_s1[a]),
			.den(dir_s1[a]),
			.quo(thi[a])
		);
	end

	always_comb begin
		miss_any = 1'b0;
		for (int a = 0; a < NA; a++) begin
			miss_any = miss_any || (flg_s[DL][a].zero_dir && !flg_s[DL][a].in_slab);
		end
	end

	// order each slab, zero direction gives the whole line
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NA; a++) begin
				if (flg_s[DL][a].zero_dir) begin
					tin_s2[a]  <= {1'b1, {(W-1){1'b0}}};
					tout_s2[a] <= {1'b0, {(W-1){1'b1}}};
				end else if (tlo[a] > thi[a]) begin
					tin_s2[a]  <= thi[a];
					tout_s2[a] <= tlo[a];
				end else begin
					tin_s2[a]  <= tlo[a];
					tout_s2[a] <= thi[a];
				end
			end
			miss_s2 <= miss_any;
		end
	end

	always_comb begin
		in_max  = tin_s2[0];
		out_min = tout_s2[0];
		for (int a = 1; a < NA; a++) begin
			if (tin_s2[a] > in_max) begin
				in_max = tin_s2[a];
			end
			if (tout_s2[a] < out_min) begin
				out_min = tout_s2[a];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tmax_s3 <= in_max;
			tmin_s3 <= out_min;
			miss_s3 <= miss_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit <= !miss_s3 && (tmax_s3 <= tmin_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s2    <= vld_s[DL];
			vld_s3    <= vld_s2;
			out_valid <= vld_s3;
		end
	end

endmodule
